FILE: rtl/core/ile_pkg.sv
package ile_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int POS_W        = 7;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    // Largest position the request field can carry
    localparam int POS_MAX      = (1 << POS_W) - 1;

    localparam logic [OP_W-1:0] OP_GET    = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item_value;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [STATUS_W-1:0]      status;
        logic [POS_W-1:0]         entry_total;
    } out_t;

    // Broadcast from the control to every cell of the row
    typedef struct packed {
        logic                     insert_en;
        logic                     delete_en;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] item;
    } cell_ctrl_t;

endpackage

FILE: rtl/core/indexed_list_engine_unit.sv
// Channel | Direction | Payload          | Handshake
// in      | into unit | ile_pkg::in_t    | in_valid / in_stall
// out     | from unit | ile_pkg::out_t   | out_valid / out_stall
//
// Each entry has its own cell. On insert the addressed cell takes the item and
// cells above it take their lower neighbor; on delete cells from the position up
// take their upper neighbor, all in the same edge. The result enters the output
// register at the accepting edge and is offered from the next cycle. Reset empties
// the list at once (count to zero); cell contents are left as they are. in_stall
// rises only while a result waits in the output register and out_stall holds it.
module indexed_list_engine_unit #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  ile_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output ile_pkg::out_t out_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    ile_pkg::out_t       out_data_reg;
    ile_pkg::out_t       result;
    ile_pkg::cell_ctrl_t ctrl;
    logic                accept;
    logic [XW-1:0]       pos_x;
    logic [XW-1:0]       count_x;
    logic                full;

    logic signed [ile_pkg::DATA_W-1:0] cell_value [CAPACITY];
    logic signed [ile_pkg::DATA_W-1:0] cell_rd    [CAPACITY];
    logic signed [ile_pkg::DATA_W-1:0] rd_any;

    assign accept  = in_valid && !in_stall;
    assign in_stall = out_valid_reg && out_stall;
    assign pos_x   = XW'(in_data.position);
    assign count_x = XW'(count_reg);
    assign full    = (count_reg == CW'(CAPACITY));

    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
            rd_any = rd_any | cell_rd[i];
    end

    always_comb
    begin
        ctrl.insert_en = 1'b0;
        ctrl.delete_en = 1'b0;
        ctrl.position  = in_data.position;
        ctrl.item      = in_data.item_value;
        count_next     = count_reg;
        result.read_value = '0;
        result.status     = ile_pkg::ST_DONE;
        case (in_data.operation)
            ile_pkg::OP_GET:
            begin
                if (pos_x < count_x)
                    result.read_value = rd_any;
                else
                begin
                    result.read_value = ile_pkg::MISS_VALUE;
                    result.status     = ile_pkg::ST_RANGE;
                end
            end
            ile_pkg::OP_INSERT:
            begin
                if (pos_x > count_x)
                    result.status = ile_pkg::ST_RANGE;
                else if (full)
                    result.status = ile_pkg::ST_FULL;
                else
                begin
                    ctrl.insert_en = accept;
                    count_next     = count_reg + CW'(1);
                end
            end
            ile_pkg::OP_DELETE:
            begin
                if (pos_x >= count_x)
                    result.status = ile_pkg::ST_RANGE;
                else
                begin
                    ctrl.delete_en = accept;
                    count_next     = count_reg - CW'(1);
                end
            end
            default:
            begin
                result.status = ile_pkg::ST_RANGE;
            end
        endcase
        result.entry_total = ile_pkg::POS_W'(count_next);
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [ile_pkg::DATA_W-1:0] left_in;
            logic signed [ile_pkg::DATA_W-1:0] right_in;
            if (g == 0)
            begin : g_head
                assign left_in = '0;
            end
            else
            begin : g_mid_l
                assign left_in = cell_value[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_tail
                assign right_in = '0;
            end
            else
            begin : g_mid_r
                assign right_in = cell_value[g+1];
            end
            ile_cell #(
                .IDX (g)
            ) u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .left  (left_in),
                .right (right_in),
                .value (cell_value[g]),
                .rd    (cell_rd[g])
            );
        end
    endgenerate

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.insert_en |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the list");

    a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.delete_en |=> count_reg == $past(count_reg) - CW'(1))
        else $error("delete did not shrink the list");

    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.status == ile_pkg::ST_FULL |-> full)
        else $error("full status on a list with room");

    a_shift_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.insert_en && ctrl.delete_en))
        else $error("insert and delete in the same cycle");

endmodule

FILE: rtl/core/ile_cell.sv
module ile_cell #(
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  ile_pkg::cell_ctrl_t               ctrl,
    input  logic signed [ile_pkg::DATA_W-1:0] left,
    input  logic signed [ile_pkg::DATA_W-1:0] right,
    output logic signed [ile_pkg::DATA_W-1:0] value,
    output logic signed [ile_pkg::DATA_W-1:0] rd
);

    // Cells past the largest position are always above any request position
    localparam logic                      FAR     = (IDX > ile_pkg::POS_MAX);
    localparam logic [ile_pkg::POS_W-1:0] IDX_LOW = ile_pkg::POS_W'(IDX);

    logic signed [ile_pkg::DATA_W-1:0] value_reg;
    logic signed [ile_pkg::DATA_W-1:0] value_next;
    logic                              hit;
    logic                              above;

    assign hit   = !FAR && (ctrl.position == IDX_LOW);
    assign above = FAR || (ctrl.position < IDX_LOW);

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.insert_en)
        begin
            if (hit)
                value_next = ctrl.item;
            else if (above)
                value_next = left;
        end
        else if (ctrl.delete_en)
        begin
            if (hit || above)
                value_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign rd    = hit ? value_reg : '0;

endmodule

FILE: bench/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP     = ile_pkg::CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1475;
    localparam int PAUSE_AT     = 600;
    localparam int IDLE_PCT     = 28;
    localparam int HOLD_CYCLES  = 250;
    localparam int LIMIT_CYCLES = 200000;
    localparam int REPORT_MAX   = 10;

    // The package names only the three defined operations
    localparam logic [ile_pkg::OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct {
        ile_pkg::in_t req;
        bit           wait_empty;
    } pending_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic          in_valid  = 1'b0;
    ile_pkg::in_t  in_data   = '0;
    logic          out_stall = 1'b0;
    logic          in_stall;
    logic          out_valid;
    ile_pkg::out_t out_data;

    logic  in_taken  = 1'b0;
    logic  calm;

    pending_t      pending[$];
    ile_pkg::out_t expected_results[$];

    // Predicted list contents
    logic signed [ile_pkg::DATA_W-1:0] list_mem [LIST_CAP];
    int list_len = 0;

    int gen_len        = 0;
    int requests_taken = 0;
    int results_seen   = 0;
    int mismatches     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    int cycle_count    = 0;

    indexed_list_engine_unit #(
        .CAPACITY (LIST_CAP)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // No idling on either side through this window
    assign calm = (requests_taken >= 900) && (requests_taken < 1150);

    function automatic ile_pkg::out_t apply_list_op(input ile_pkg::in_t req);
        ile_pkg::out_t res;
        int            pos;
        int            slot;
        pos            = req.position;
        res.read_value = '0;
        res.status     = ile_pkg::ST_DONE;
        case (req.operation)
            ile_pkg::OP_GET:
            begin
                if (pos < list_len)
                begin
                    res.read_value = list_mem[pos];
                end
                else
                begin
                    res.read_value = ile_pkg::MISS_VALUE;
                    res.status     = ile_pkg::ST_RANGE;
                end
            end
            ile_pkg::OP_INSERT:
            begin
                if (pos > list_len)
                begin
                    res.status = ile_pkg::ST_RANGE;
                end
                else if (list_len >= LIST_CAP)
                begin
                    res.status = ile_pkg::ST_FULL;
                end
                else
                begin
                    for (slot = list_len; slot > pos; slot--)
                    begin
                        list_mem[slot] = list_mem[slot - 1];
                    end
                    list_mem[pos] = req.item_value;
                    list_len++;
                end
            end
            ile_pkg::OP_DELETE:
            begin
                if (pos >= list_len)
                begin
                    res.status = ile_pkg::ST_RANGE;
                end
                else
                begin
                    for (slot = pos; slot + 1 < list_len; slot++)
                    begin
                        list_mem[slot] = list_mem[slot + 1];
                    end
                    list_len--;
                end
            end
            default:
            begin
                res.status = ile_pkg::ST_RANGE;
            end
        endcase
        res.entry_total = ile_pkg::POS_W'(list_len);
        return res;
    endfunction

    task automatic queue_request(input logic [ile_pkg::OP_W-1:0] op,
                                 input int pos,
                                 input logic [ile_pkg::DATA_W-1:0] val,
                                 input bit wait_empty);
        pending_t item;
        item.req.operation  = op;
        item.req.position   = pos[ile_pkg::POS_W-1:0];
        item.req.item_value = val;
        item.wait_empty     = wait_empty;
        pending.push_back(item);
        // Track the length only, so random positions land in range
        case (op)
            ile_pkg::OP_INSERT:
            begin
                if (pos <= gen_len && gen_len < LIST_CAP)
                begin
                    gen_len++;
                end
            end
            ile_pkg::OP_DELETE:
            begin
                if (pos < gen_len)
                begin
                    gen_len--;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    function automatic logic [ile_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Stimulus
    initial
    begin
        int                           queued;
        int                           r;
        int                           pos;
        bit                           noise;
        bit                           filling;
        logic [ile_pkg::OP_W-1:0]     op;

        // empty list, then head, tail and middle inserts
        queue_request(ile_pkg::OP_GET,    0, 32'h0, 1'b0);
        queue_request(ile_pkg::OP_DELETE, 0, 32'h0, 1'b0);
        queue_request(ile_pkg::OP_INSERT, 1, 32'h1234_5678, 1'b0);
        queue_request(ile_pkg::OP_INSERT, 0, 32'h8000_0000, 1'b0);
        queue_request(ile_pkg::OP_INSERT, 1, 32'h7fff_ffff, 1'b0);
        queue_request(ile_pkg::OP_INSERT, 1, 32'hffff_ffff, 1'b0);
        queue_request(ile_pkg::OP_INSERT, 0, 32'h0000_0000, 1'b0);
        queue_request(ile_pkg::OP_GET,    0, 32'h0, 1'b0);
        queue_request(ile_pkg::OP_GET,    1, 32'h0, 1'b0);
        queue_request(ile_pkg::OP_GET,    2, 32'h0, 1'b0);
        queue_request(ile_pkg::OP_GET,    3, 32'h0, 1'b0);
        queue_request(ile_pkg::OP_GET,    4, 32'h0, 1'b0);
        queue_request(ile_pkg::OP_GET,    ile_pkg::POS_MAX, 32'hffff_ffff, 1'b0);
        queue_request(ile_pkg::OP_INSERT, 5, 32'hdead_beef, 1'b0);
        queue_request(ile_pkg::OP_INSERT, ile_pkg::POS_MAX, 32'hffff_ffff, 1'b0);
        queue_request(ile_pkg::OP_DELETE, 4, 32'h0, 1'b0);
        queue_request(ile_pkg::OP_DELETE, ile_pkg::POS_MAX, 32'hffff_ffff, 1'b0);
        queue_request(OP_SPARE,           0, 32'h0, 1'b0);
        queue_request(OP_SPARE,           ile_pkg::POS_MAX, 32'hffff_ffff, 1'b0);
        queue_request(ile_pkg::OP_DELETE, 1, 32'h0, 1'b0);
        queue_request(ile_pkg::OP_DELETE, 2, 32'h0, 1'b0);
        queue_request(ile_pkg::OP_DELETE, 0, 32'h0, 1'b0);
        queue_request(ile_pkg::OP_GET,    0, 32'h0, 1'b0);
        queue_request(ile_pkg::OP_DELETE, 0, 32'h0, 1'b0);
        queue_request(ile_pkg::OP_INSERT, 0, 32'h5555_5555, 1'b0);

        // Random part: fill to capacity, lean on the full list, drain, repeat
        queued  = 0;
        filling = 1'b1;
        while (queued < RANDOM_ITEMS)
        begin
            if (filling && gen_len == LIST_CAP && $urandom_range(3) == 0)
            begin
                filling = 1'b0;
            end
            else if (!filling && gen_len == 0 && $urandom_range(1) == 0)
            begin
                filling = 1'b1;
            end
            r = $urandom_range(99);
            if (r >= 97)
            begin
                op = OP_SPARE;
            end
            else if (filling)
            begin
                op = (r < 65) ? ile_pkg::OP_INSERT :
                     (r < 85) ? ile_pkg::OP_GET : ile_pkg::OP_DELETE;
            end
            else
            begin
                op = (r < 60) ? ile_pkg::OP_DELETE :
                     (r < 80) ? ile_pkg::OP_GET : ile_pkg::OP_INSERT;
            end
            noise = ($urandom_range(99) < 8);
            if (noise)
            begin
                pos = $urandom_range(ile_pkg::POS_MAX);
            end
            else if (op == ile_pkg::OP_INSERT)
            begin
                pos = $urandom_range(gen_len);
            end
            else
            begin
                pos = (gen_len == 0) ? 0 : $urandom_range(gen_len - 1);
            end
            queue_request(op, pos, pick_value(), queued == PAUSE_AT);
            queued++;
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Request driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (pending.size() == 0 ||
                (pending[0].wait_empty && expected_results.size() != 0) ||
                (!calm && $urandom_range(99) < IDLE_PCT))
            begin
                in_valid <= 1'b0;
            end
            else
            begin
                in_data  <= pending[0].req;
                in_valid <= 1'b1;
                void'(pending.pop_front());
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && results_seen >= 400)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Monitor: check results, then predict newly accepted requests
    always @(posedge clk)
    begin : monitor
        ile_pkg::out_t want;
        in_taken <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $display("unexpected result: read_value=%0d status=%0d total=%0d",
                                 out_data.read_value, out_data.status,
                                 out_data.entry_total);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.read_value !== want.read_value ||
                        out_data.status !== want.status ||
                        out_data.entry_total !== want.entry_total)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display({"result %0d: expected read_value=%0d",
                                      " status=%0d total=%0d,"},
                                     results_seen, want.read_value, want.status,
                                     want.entry_total);
                            $display("    got read_value=%0d status=%0d total=%0d",
                                     out_data.read_value, out_data.status,
                                     out_data.entry_total);
                        end
                    end
                end
                results_seen++;
            end
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(apply_list_op(in_data));
                requests_taken++;
            end
        end
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

FILE: indexed_list_engine_unit.f
rtl/core/ile_pkg.sv
rtl/core/ile_cell.sv
rtl/core/indexed_list_engine_unit.sv
bench/testbench.sv
